// ===== hw/rtl/fss_pkg.sv =====
// package: shared types, constants, microcode rom and q15 rounding for the series synthesizer
`timescale 1ns / 1ps
`default_nettype none
package fss_pkg;

	// field widths fixed by the item format
	localparam int OP_W    = 1;
	localparam int TI_W    = 6;
	localparam int DATA_W  = 16;
	localparam int SI_W    = 7;
	localparam int OUT_W   = 40;
	localparam int PROD_W  = 2 * DATA_W;

	// highest number of terms whose coefficients can be loaded
	localparam int STORE_MAX = 64;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
	localparam logic [OP_W-1:0] OP_EVAL = 1'b1;

	// fixed point constants for the trig table series
	localparam longint PI_Q28  = 64'sd843314857;
	localparam longint ONE_Q28 = 64'sd268435456;
	localparam int     SERIES_TERMS = 14;

	// microcode addresses
	typedef logic [2:0] upc_t;
	localparam upc_t UPC_FETCH  = 3'd0;
	localparam upc_t UPC_REDUCE = 3'd1;
	localparam upc_t UPC_INIT   = 3'd2;
	localparam upc_t UPC_LOOP   = 3'd3;
	localparam upc_t UPC_DRAIN0 = 3'd4;
	localparam upc_t UPC_DRAIN1 = 3'd5;
	localparam upc_t UPC_POST   = 3'd6;

	// branch conditions
	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_EVAL_IN,
		COND_K_IN_RANGE,
		COND_LAST_TERM,
		COND_OUT_FREE
	} cond_t;

	// one control word; the step holds until its condition is met
	typedef struct packed {
		cond_t cond;
		upc_t  target;
		logic  accept;
		logic  k_load;
		logic  k_reduce;
		logic  clear;
		logic  issue;
		logic  out_load;
	} uword_t;

	// status from the datapath back to the sequencer
	typedef struct packed {
		logic eval_in;
		logic k_in_range;
		logic last_term;
		logic out_free;
	} flags_t;

	// control program
	function automatic uword_t ucode_rom(input upc_t pc);
		uword_t w;
		w = '0;
		unique case (pc)
			UPC_FETCH: begin
				w.cond = COND_EVAL_IN;
				w.target = UPC_REDUCE;
				w.accept = 1'b1;
				w.k_load = 1'b1;
			end
			UPC_REDUCE: begin
				w.cond = COND_K_IN_RANGE;
				w.target = UPC_INIT;
				w.k_reduce = 1'b1;
			end
			UPC_INIT: begin
				w.cond = COND_ALWAYS;
				w.target = UPC_LOOP;
				w.clear = 1'b1;
			end
			UPC_LOOP: begin
				w.cond = COND_LAST_TERM;
				w.target = UPC_DRAIN0;
				w.issue = 1'b1;
			end
			UPC_DRAIN0: begin
				w.cond = COND_ALWAYS;
				w.target = UPC_DRAIN1;
			end
			UPC_DRAIN1: begin
				w.cond = COND_ALWAYS;
				w.target = UPC_POST;
			end
			UPC_POST: begin
				w.cond = COND_OUT_FREE;
				w.target = UPC_FETCH;
				w.out_load = 1'b1;
			end
			default: begin
				w.cond = COND_ALWAYS;
				w.target = UPC_FETCH;
			end
		endcase
		return w;
	endfunction

	// q4.28 to q1.15, round half away from zero, saturate
	function automatic logic [DATA_W-1:0] q28_to_q15(input longint v);
		longint mag;
		longint r;
		mag = (v < 0) ? -v : v;
		r = (mag + 64'sd4096) >>> 13;
		if (v < 0)
			r = -r;
		if (r > 64'sd32767)
			r = 64'sd32767;
		if (r < -64'sd32768)
			r = -64'sd32768;
		return r[DATA_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fss_if.sv =====
// interfaces: input item channel and result channel of the series synthesizer
`timescale 1ns / 1ps
`default_nettype none
interface fss_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [fss_pkg::OP_W-1:0]             operation;
	logic [fss_pkg::TI_W-1:0]             term_index;
	logic signed [fss_pkg::DATA_W-1:0]    cos_coeff;
	logic signed [fss_pkg::DATA_W-1:0]    sin_coeff;
	logic [fss_pkg::SI_W-1:0]             sample_index;

	modport source (
		output valid, operation, term_index, cos_coeff, sin_coeff, sample_index,
		input  ready
	);
	modport sink (
		input  valid, operation, term_index, cos_coeff, sin_coeff, sample_index,
		output ready
	);
endinterface

interface fss_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [fss_pkg::OUT_W-1:0]     sample_value;

	modport source (
		output valid, sample_value,
		input  ready
	);
	modport sink (
		input  valid, sample_value,
		output ready
	);
endinterface
`default_nettype wire

// ===== hw/rtl/fss_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module fss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/fss_seq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
`timescale 1ns / 1ps
`default_nettype none
module fss_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fss_pkg::flags_t flags,
	output fss_pkg::uword_t      uword
);

	fss_pkg::upc_t pc_q;
	logic          cond_met;

	// control word of the current step
	assign uword = fss_pkg::ucode_rom(pc_q);

	// condition select
	always_comb begin
		unique case (uword.cond)
			fss_pkg::COND_ALWAYS:     cond_met = 1'b1;
			fss_pkg::COND_EVAL_IN:    cond_met = flags.eval_in;
			fss_pkg::COND_K_IN_RANGE: cond_met = flags.k_in_range;
			fss_pkg::COND_LAST_TERM:  cond_met = flags.last_term;
			fss_pkg::COND_OUT_FREE:   cond_met = flags.out_free;
			default:                  cond_met = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= fss_pkg::UPC_FETCH;
		end else if (cond_met) begin
			pc_q <= uword.target;
		end
	end

	// the program never reaches the unused address
	a_pc_legal: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q != 3'd7)
		else $error("sequencer at unused address");

	// the loop step is only entered from the init step
	a_loop_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == fss_pkg::UPC_LOOP && $past(pc_q) != fss_pkg::UPC_LOOP)
		|-> $past(pc_q) == fss_pkg::UPC_INIT)
		else $error("loop entered without init");

	// an evaluate transfer always starts the reduction step
	a_fetch_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == fss_pkg::UPC_FETCH && flags.eval_in) |=> pc_q == fss_pkg::UPC_REDUCE)
		else $error("evaluate transfer not followed by reduction");

endmodule
`default_nettype wire

// ===== hw/rtl/fourier_series_synthesizer.sv =====
// top level: fourier series synthesizer with coefficient store and microcoded mac
// Usage
// - in_ch carries items: operation 0 loads the cosine/sine pair of term_index,
//   operation 1 evaluates the sample at sample_index k, t = k / (2*TERMS).
// - out_ch carries one 40-bit sample_value per evaluate, scaled by 2^15; a load
//   gives no result.
// - A load transfer does not leave the fetch step; the block is ready again in the next cycle.
// - An evaluate passes from transfer to the result register through the reduction
//   step (repeated once per wrap of k), the init step, the loop step that sends
//   the terms through the single shared multiply-accumulate (one term a cycle),
//   and the drain of the read/multiply/add pipeline.
// - One item is worked at a time; ready is high only in the fetch step.
// - The result sits in an output register: the next item is taken while it
//   waits, and only a following evaluate waits for the slot to free.
// - Reset clears the coefficient valid bits, so all coefficients read as zero,
//   and empties the output register. The trig table is constant.
// - Terms at or above 64 cannot be loaded and stay zero; loads of a term index
//   at or above TERMS are dropped.
`timescale 1ns / 1ps
`default_nettype none
module fourier_series_synthesizer #(
	parameter int TERMS = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fss_in_if.sink     in_ch,
	fss_out_if.source  out_ch
);

	localparam int TAB_LEN = 2 * TERMS;
	localparam int IW      = $clog2(TAB_LEN);
	localparam int TW      = $clog2(TERMS);
	localparam int DEPTH   = (TERMS < fss_pkg::STORE_MAX) ? TERMS : fss_pkg::STORE_MAX;
	localparam int AW      = $clog2(DEPTH);
	localparam int SW      = ((IW > fss_pkg::SI_W) ? IW : fss_pkg::SI_W) + 1;
	localparam int DW      = fss_pkg::DATA_W;
	localparam int CW      = 2 * DW;

	// taylor series of sin in q4.28, each term truncated toward zero
	function automatic longint series_sin(input longint th, input longint t2);
		longint t, acc;
		t = th;
		acc = th;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd6;   acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd20;  acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd42;  acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd72;  acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd110; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd156; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd210; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd272; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd342; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd420; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd506; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd600; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd702; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd812; acc = acc + t;
		return acc;
	endfunction

	// taylor series of cos in q4.28, each term truncated toward zero
	function automatic longint series_cos(input longint t2);
		longint t, acc;
		t = fss_pkg::ONE_Q28;
		acc = fss_pkg::ONE_Q28;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd2;   acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd12;  acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd30;  acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd56;  acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd90;  acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd132; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd182; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd240; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd306; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd380; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd462; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd552; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd650; acc = acc + t;
		t = -((t * t2) / fss_pkg::ONE_Q28) / 64'sd756; acc = acc + t;
		return acc;
	endfunction

	// cosine or sine table of TAB_LEN entries in q1.15, built at elaboration
	function automatic logic [TAB_LEN*DW-1:0] build_tab(input logic want_sin);
		longint js, th, t2;
		logic [TAB_LEN*DW-1:0] tab;
		tab = '0;
		for (int j = 0; j < TAB_LEN; j++) begin
			js = (2 * j < TAB_LEN) ? longint'(j) : longint'(j - TAB_LEN);
			th = (64'sd2 * fss_pkg::PI_Q28 * js) / TAB_LEN;
			t2 = (th * th) / fss_pkg::ONE_Q28;
			tab[j*DW +: DW] = want_sin ? fss_pkg::q28_to_q15(series_sin(th, t2))
				: fss_pkg::q28_to_q15(series_cos(t2));
		end
		return tab;
	endfunction

	localparam logic [TAB_LEN*DW-1:0] COS_TAB = build_tab(1'b0);
	localparam logic [TAB_LEN*DW-1:0] SIN_TAB = build_tab(1'b1);

	fss_pkg::uword_t uw;
	fss_pkg::flags_t flags;

	logic                          in_xfer;
	logic                          coef_we;
	logic [DEPTH-1:0]              valid_q;
	logic [CW-1:0]                 coef_rdata;

	logic [fss_pkg::SI_W-1:0]      k_q;
	logic [SW-1:0]                 k_ext;
	logic [SW-1:0]                 idx_sum;
	logic [IW-1:0]                 idx_q;
	logic [TW-1:0]                 term_q;
	logic                          term_stored;

	logic                          valid_s1;
	logic                          coef_ok_s1;
	logic signed [DW-1:0]          cos_s1;
	logic signed [DW-1:0]          sin_s1;
	logic signed [DW-1:0]          cos_coef;
	logic signed [DW-1:0]          sin_coef;

	logic                          valid_s2;
	logic signed [CW-1:0]          prod_c_s2;
	logic signed [CW-1:0]          prod_s_s2;
	logic signed [CW:0]            pair_sum;

	logic signed [fss_pkg::OUT_W-1:0] acc_q;
	logic signed [fss_pkg::OUT_W-1:0] out_q;
	logic                          out_valid_q;
	logic                          out_free;
	logic                          out_load_en;

	// sequencer
	fss_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uword  (uw)
	);

	// input handshake and coefficient writes
	assign in_ch.ready = uw.accept;
	assign in_xfer     = in_ch.valid & uw.accept;
	assign coef_we     = in_xfer & (in_ch.operation == fss_pkg::OP_LOAD)
		& (32'(in_ch.term_index) < TERMS);

	fss_ram #(
		.WIDTH (CW),
		.DEPTH (DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (in_ch.term_index[AW-1:0]),
		.wdata ({in_ch.cos_coeff, in_ch.sin_coeff}),
		.raddr (term_q[AW-1:0]),
		.rdata (coef_rdata)
	);

	// angle index step and sample index reduction
	assign k_ext       = SW'(k_q);
	assign idx_sum     = SW'(idx_q) + k_ext;
	assign term_stored = 32'(term_q) < DEPTH;

	// status flags
	assign out_free         = !out_valid_q || out_ch.ready;
	assign flags.eval_in    = in_xfer & (in_ch.operation == fss_pkg::OP_EVAL);
	assign flags.k_in_range = k_ext < SW'(TAB_LEN);
	assign flags.last_term  = term_q == TW'(TERMS - 1);
	assign flags.out_free   = out_free;

	assign out_load_en = uw.out_load & out_free;

	// coefficient gating: unwritten entries read as zero
	assign cos_coef = coef_ok_s1 ? coef_rdata[CW-1:DW] : '0;
	assign sin_coef = coef_ok_s1 ? coef_rdata[DW-1:0]  : '0;
	assign pair_sum = (CW+1)'(prod_c_s2) + (CW+1)'(prod_s_s2);

	// payload registers: sample index, index walk, table read, products, output data
	always_ff @(posedge clk) begin
		if (uw.k_load && flags.eval_in)
			k_q <= in_ch.sample_index;
		else if (uw.k_reduce && !flags.k_in_range)
			k_q <= fss_pkg::SI_W'(k_ext - SW'(TAB_LEN));

		if (uw.clear) begin
			idx_q  <= '0;
			term_q <= '0;
		end else if (uw.issue) begin
			idx_q  <= (idx_sum >= SW'(TAB_LEN)) ? IW'(idx_sum - SW'(TAB_LEN)) : IW'(idx_sum);
			term_q <= term_q + 1'b1;
		end

		coef_ok_s1 <= valid_q[term_q[AW-1:0]] & term_stored;
		cos_s1     <= COS_TAB[{idx_q, 4'b0000} +: DW];
		sin_s1     <= SIN_TAB[{idx_q, 4'b0000} +: DW];

		prod_c_s2 <= cos_coef * cos_s1;
		prod_s_s2 <= sin_coef * sin_s1;

		if (out_load_en)
			out_q <= acc_q;
	end

	// control registers: valid bits, pipeline valids, accumulator, output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (coef_we)
				valid_q[in_ch.term_index[AW-1:0]] <= 1'b1;
			valid_s1 <= uw.issue;
			valid_s2 <= valid_s1;
			if (uw.clear)
				acc_q <= '0;
			else if (valid_s2)
				acc_q <= acc_q + fss_pkg::OUT_W'(pair_sum);
			if (out_load_en)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	// result channel
	assign out_ch.valid        = out_valid_q;
	assign out_ch.sample_value = out_q;

	// no item is taken while terms are still in the pipeline
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 || valid_s2 || uw.issue) |-> !in_ch.ready)
		else $error("input ready while evaluation in flight");

	// the walk always works with a reduced sample index
	a_k_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		uw.issue |-> flags.k_in_range)
		else $error("term issued with unreduced sample index");

	// the walk starts at term zero and angle zero
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(uw.issue) |-> (term_q == '0 && idx_q == '0))
		else $error("term walk did not start from zero");

	// the result is taken only after the pipeline has drained
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		uw.out_load |-> (!valid_s1 && !valid_s2))
		else $error("result loaded before pipeline drained");

	// a loaded result shows up on the channel
	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load_en |=> out_valid_q)
		else $error("loaded result not presented");

endmodule
`default_nettype wire
